// ===== src/uart_packet_ring_resync_assert.svh =====
// Assertion macros used by the controller of the receive ring.
`ifndef UART_PACKET_RING_RESYNC_ASSERT_SVH
`define UART_PACKET_RING_RESYNC_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define UPRR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uprr: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define UPRR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uprr: next-cycle check failed");

`endif

// ===== src/uprr_pkg.sv =====
package uprr_pkg;

    // Default geometry of the ring and of the two packet kinds.
    localparam int RING_DEPTH_DEF    = 64;
    localparam int PACKET_BYTES_DEF  = 16;
    localparam int ACK_MAX_BYTES_DEF = 32;

    // Address width of the memory request; wide enough for the deepest ring.
    localparam int ADDR_W = 8;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_MIN = 1'b1;
    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [5:0] ACK_MIN_RESET = 6'd2;

    // The two characters that open an acknowledge packet.
    localparam logic [7:0] ASCII_O = 8'h4F;
    localparam logic [7:0] ASCII_K = 8'h4B;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_DATA = 2'd1,
        OP_ACK  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_ACK  = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_D_CHECK,
        S_D_CMP,
        S_A_CHECK,
        S_A_RD1,
        S_A_CMP,
        S_STREAM
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       last;
        logic [7:0] packet_total;
        logic       ack_seen;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== src/uprr_ring_mem.sv =====
module uprr_ring_mem
    import uprr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [7:0] r_mem [RING_DEPTH];
    logic [7:0] r_rdata;

    // One write port and one read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[PTR_W-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[PTR_W-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/uprr_ctrl.sv =====
module uprr_ctrl
    import uprr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int PACKET_BYTES  = PACKET_BYTES_DEF,
    parameter int ACK_MAX_BYTES = ACK_MAX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_cmd                 i_cmd,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output t_mem_req             o_mem_req,
    input  logic [7:0]           i_rdata,
    output logic                 o_res_strobe,
    output t_res                 o_res
);

    `include "uart_packet_ring_resync_assert.svh"

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int MAX_LEN = (PACKET_BYTES > ACK_MAX_BYTES) ? PACKET_BYTES : ACK_MAX_BYTES;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int CMP_W   = FILL_W + 7;
    localparam int DIF_W   = FILL_W + 1;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_cnt, n_cnt;
    logic              r_ack, n_ack;
    logic [7:0]        r_header;
    logic [5:0]        r_ack_min;
    logic [PTR_W-1:0]  r_addr, n_addr;
    logic [LEN_W-1:0]  r_k, n_k;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CMP_W-1:0]  r_lim, n_lim;
    t_status           r_status, n_status;
    logic [7:0]        r_b0, n_b0;
    logic              r_out_valid, n_out_valid;
    logic              r_out_last, n_out_last;
    logic              r_out_zero, n_out_zero;
    t_status           r_out_status, n_out_status;

    logic              accept;
    logic              acc_rx;
    logic [DIF_W-1:0]  wp_x;
    logic [DIF_W-1:0]  fill_x;
    logic [PTR_W-1:0]  oldest;
    logic [PTR_W-1:0]  oldest_nx;
    logic [PTR_W-1:0]  addr_nx;
    logic [CMP_W-1:0]  fill_c;
    logic              data_ok;
    logic              ack_win;
    logic [7:0]        b1;
    logic              ok_match;
    logic              stream_last;
    logic              ring_full;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] a);
        return (a == PTR_W'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign acc_rx = accept && (i_cmd.opcode == OP_RX);

    // Oldest entry sits fill places behind the write pointer, modulo the depth.
    assign wp_x      = DIF_W'(r_wp);
    assign fill_x    = DIF_W'(r_fill);
    assign oldest    = (wp_x >= fill_x) ? PTR_W'(wp_x - fill_x)
                                        : PTR_W'(wp_x + DIF_W'(RING_DEPTH) - fill_x);
    assign oldest_nx = ptr_inc(oldest);
    assign addr_nx   = ptr_inc(r_addr);

    // Search conditions and the decision on a candidate.
    assign fill_c      = CMP_W'(r_fill);
    assign ring_full   = (fill_c >= CMP_W'(RING_DEPTH));
    assign data_ok     = (fill_c >= CMP_W'(PACKET_BYTES));
    assign ack_win     = (fill_c >= CMP_W'(r_ack_min)) && (fill_c < CMP_W'(ACK_MAX_BYTES))
                         && (r_fill != '0);
    assign b1          = (fill_c >= CMP_W'(2)) ? i_rdata : 8'h00;
    assign ok_match    = (r_b0 == ASCII_O) && (b1 == ASCII_K);
    assign stream_last = (r_k == r_len - 1'b1);

    // Memory request: writes come only from received bytes, reads from the sequencer.
    always_comb begin
        o_mem_req.we    = acc_rx && !ring_full;
        o_mem_req.waddr = ADDR_W'(r_wp);
        o_mem_req.wdata = i_cmd.rx_byte;
        case (r_state)
            S_A_RD1:  o_mem_req.raddr = ADDR_W'(oldest_nx);
            S_STREAM: o_mem_req.raddr = ADDR_W'(r_addr);
            default:  o_mem_req.raddr = ADDR_W'(oldest);
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_DATA: n_state = S_D_CHECK;
                        OP_ACK:  n_state = S_A_CHECK;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_D_CHECK: n_state = data_ok ? S_D_CMP : S_IDLE;
            S_D_CMP:   n_state = (i_rdata == r_header) ? S_STREAM : S_D_CHECK;
            S_A_CHECK: n_state = ack_win ? S_A_RD1 : S_IDLE;
            S_A_RD1:   n_state = S_A_CMP;
            S_A_CMP: begin
                if (ok_match) begin
                    n_state = S_STREAM;
                end else if (r_b0 == r_header) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_A_CHECK;
                end
            end
            S_STREAM:  n_state = stream_last ? S_IDLE : S_STREAM;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and result values for each state.
    always_comb begin
        n_wp         = r_wp;
        n_fill       = r_fill;
        n_cnt        = r_cnt;
        n_ack        = r_ack;
        n_addr       = r_addr;
        n_k          = r_k;
        n_len        = r_len;
        n_lim        = r_lim;
        n_status     = r_status;
        n_b0         = r_b0;
        n_out_valid  = 1'b0;
        n_out_last   = 1'b0;
        n_out_zero   = 1'b0;
        n_out_status = r_out_status;
        case (r_state)
            S_IDLE: begin
                // A byte into a full ring empties it and is lost.
                if (acc_rx) begin
                    if (ring_full) begin
                        n_fill = '0;
                    end else begin
                        n_wp   = ptr_inc(r_wp);
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            S_D_CHECK: begin
                if (!data_ok) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_zero   = 1'b1;
                    n_out_status = ST_NONE;
                end
            end
            S_D_CMP: begin
                if (i_rdata == r_header) begin
                    n_addr   = oldest;
                    n_fill   = FILL_W'(fill_c - CMP_W'(PACKET_BYTES));
                    n_cnt    = r_cnt + 1'b1;
                    n_k      = '0;
                    n_len    = LEN_W'(PACKET_BYTES);
                    n_lim    = CMP_W'(PACKET_BYTES);
                    n_status = ST_DATA;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            S_A_CHECK: begin
                if (!ack_win) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_zero   = 1'b1;
                    n_out_status = ST_NONE;
                end
            end
            S_A_RD1: begin
                n_b0 = i_rdata;
            end
            S_A_CMP: begin
                if (ok_match) begin
                    // Bytes past the fill count pad the packet with zeros.
                    n_addr   = oldest;
                    n_lim    = fill_c;
                    n_fill   = '0;
                    n_ack    = 1'b1;
                    n_k      = '0;
                    n_len    = LEN_W'(ACK_MAX_BYTES);
                    n_status = ST_ACK;
                end else if (r_b0 == r_header) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_zero   = 1'b1;
                    n_out_status = ST_NONE;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            S_STREAM: begin
                n_addr       = addr_nx;
                n_k          = r_k + 1'b1;
                n_out_valid  = 1'b1;
                n_out_last   = stream_last;
                n_out_zero   = !(CMP_W'(r_k) < r_lim);
                n_out_status = r_status;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_ack       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_ack       <= n_ack;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_ack_min <= ACK_MIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEADER:  r_header  <= i_cfg_data;
                CFG_ACK_MIN: r_ack_min <= i_cfg_data[5:0];
                default:     r_header  <= r_header;
            endcase
        end
    end

    // Working registers of the search and the result stage.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_k          <= n_k;
        r_len        <= n_len;
        r_lim        <= n_lim;
        r_status     <= n_status;
        r_b0         <= n_b0;
        r_out_last   <= n_out_last;
        r_out_zero   <= n_out_zero;
        r_out_status <= n_out_status;
    end

    // Results line up with the registered memory read data.
    assign o_res_strobe        = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.out_byte      = r_out_zero ? 8'h00 : i_rdata;
    assign o_res.last          = r_out_last;
    assign o_res.packet_total  = r_cnt;
    assign o_res.ack_seen      = r_ack;

    `UPRR_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(RING_DEPTH))
    `UPRR_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, r_out_valid && r_out_last, r_state == S_IDLE)
    `UPRR_ASSERT_IMP(a_idle_last, i_clk, i_rst_n, r_out_valid && (r_state == S_IDLE), r_out_last)
    `UPRR_ASSERT_NXT(a_rx_fill, i_clk, i_rst_n, acc_rx && !ring_full, r_fill == $past(r_fill) + 1'b1)

endmodule

// ===== src/uart_packet_ring_resync.sv =====
// Receive ring with header resynchronisation.
// Command channel: an opcode and a byte are taken when start is high and busy
// is low. Opcode 0 stores a received byte (or empties a full ring and drops
// it); opcode 1 fetches a data packet, opcode 2 an acknowledge packet;
// opcode 3 is ignored.
// Results leave on o_res for one cycle each, marked by o_res_strobe, with last
// set on the final one of a request. The receiver cannot stall this channel.
// A data request checks each candidate byte in S_D_CHECK and S_D_CMP, then
// streams PACKET_BYTES results; an acknowledge request checks each candidate
// in S_A_CHECK, S_A_RD1 and S_A_CMP, then streams ACK_MAX_BYTES results.
// The ring memory has one registered read port. The first result appears
// in the cycle after its read; a failed search gives one result in the
// cycle after the last check. Busy falls as the final result is shown.
// Configuration writes (header byte, least ack fill count) are always ready
// and must be made while the block is idle, which the block does not enforce.
// Reset empties the ring, clears the packet count and the ack flag and loads
// the configuration defaults; no clearing pass is run.
module uart_packet_ring_resync
    import uprr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int PACKET_BYTES  = PACKET_BYTES_DEF,
    parameter int ACK_MAX_BYTES = ACK_MAX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_cmd                 i_cmd,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_res_strobe,
    output t_res                 o_res
);

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;

    assign o_cfg_ready = 1'b1;

    // Sequencer, pointers and counters.
    uprr_ctrl #(
        .RING_DEPTH    (RING_DEPTH),
        .PACKET_BYTES  (PACKET_BYTES),
        .ACK_MAX_BYTES (ACK_MAX_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mem_req    (mem_req),
        .i_rdata      (mem_rdata),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    // Ring storage.
    uprr_ring_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== test/uart_packet_ring_resync_tb.sv =====
`timescale 1ns / 1ps

module uart_packet_ring_resync_tb;
    import uprr_pkg::*;

    // Opcode 3 has no meaning and must be ignored by the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 3;
    localparam int SCRIPT_LEN  = 31;

    // One row of the directed script: a register write or a request, with an
    // optional typed-in result for the single-result rows.
    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_ix;
        logic [1:0]           op;
        logic [7:0]           val;
        logic                 typed;
        t_res                 want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_cmd                 i_cmd = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 o_res_strobe;
    t_res                 o_res;

    // Shadow copy of the ring, its registers and its counters.
    logic [7:0] ring_mem [RING_DEPTH_DEF];
    int         wr_ix = 0;
    int         held = 0;
    logic [7:0] pkt_total = 8'd0;
    logic       ack_done = 1'b0;
    logic [7:0] hdr_val = HEADER_RESET;
    logic [5:0] ack_floor = ACK_MIN_RESET;

    // Packet bytes still owed by the block, oldest first.
    t_res bytes_due [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int data_pkts = 0;
    int ack_pkts = 0;
    int empty_searches = 0;
    int burst_left = 0;
    bit idle_on = 1'b1;

    t_row script [SCRIPT_LEN];

    uart_packet_ring_resync DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_row rx_row(logic [7:0] b);
        t_row r;
        r = '0;
        r.op = OP_RX;
        r.val = b;
        return r;
    endfunction

    function automatic t_row req_row(logic [1:0] op);
        t_row r;
        r = '0;
        r.op = op;
        return r;
    endfunction

    // A request that must find nothing: status none, zero byte, last set.
    function automatic t_row fail_row(logic [1:0] op, logic [7:0] total, logic seen);
        t_row r;
        r = '0;
        r.op = op;
        r.typed = 1'b1;
        r.want.status = ST_NONE;
        r.want.last = 1'b1;
        r.want.packet_total = total;
        r.want.ack_seen = seen;
        return r;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] ix, logic [7:0] v);
        t_row r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_ix = ix;
        r.val = v;
        return r;
    endfunction

    function automatic int oldest_slot();
        return (wr_ix + RING_DEPTH_DEF - (held % RING_DEPTH_DEF)) % RING_DEPTH_DEF;
    endfunction

    function automatic void owe_byte(logic [1:0] st, logic [7:0] b, logic fin);
        t_res r;
        r.status = st;
        r.out_byte = b;
        r.last = fin;
        r.packet_total = pkt_total;
        r.ack_seen = ack_done;
        bytes_due.push_back(r);
    endfunction

    // Works out what one accepted request does to the ring and what it yields.
    function automatic void ring_apply(logic [1:0] op, logic [7:0] b);
        int s;
        bit found;
        logic [7:0] b0;
        logic [7:0] b1;
        found = 1'b0;
        if (op == OP_RX) begin
            // A byte arriving at a full ring empties it and is lost.
            if (held >= RING_DEPTH_DEF) begin
                held = 0;
            end else begin
                ring_mem[wr_ix] = b;
                wr_ix = (wr_ix + 1) % RING_DEPTH_DEF;
                held++;
            end
        end else if (op == OP_DATA) begin
            while (!found && held >= PACKET_BYTES_DEF) begin
                s = oldest_slot();
                if (ring_mem[s] == hdr_val) begin
                    held -= PACKET_BYTES_DEF;
                    pkt_total++;
                    for (int k = 0; k < PACKET_BYTES_DEF; k++) begin
                        owe_byte(ST_DATA, ring_mem[(s + k) % RING_DEPTH_DEF],
                                 k == PACKET_BYTES_DEF - 1);
                    end
                    found = 1'b1;
                end else begin
                    held--;
                end
            end
            if (!found) owe_byte(ST_NONE, 8'h00, 1'b1);
        end else if (op == OP_ACK) begin
            while (!found && held >= ack_floor && held < ACK_MAX_BYTES_DEF && held > 0) begin
                s = oldest_slot();
                b0 = ring_mem[s];
                b1 = (held > 1) ? ring_mem[(s + 1) % RING_DEPTH_DEF] : 8'h00;
                if (b0 == ASCII_O && b1 == ASCII_K) begin
                    // Bytes past the fill count are padded with zeros.
                    ack_done = 1'b1;
                    for (int k = 0; k < ACK_MAX_BYTES_DEF; k++) begin
                        owe_byte(ST_ACK, (k < held) ? ring_mem[(s + k) % RING_DEPTH_DEF] : 8'h00,
                                 k == ACK_MAX_BYTES_DEF - 1);
                    end
                    held = 0;
                    found = 1'b1;
                end else if (b0 == hdr_val) begin
                    owe_byte(ST_NONE, 8'h00, 1'b1);
                    found = 1'b1;
                end else begin
                    held--;
                end
            end
            if (!found) owe_byte(ST_NONE, 8'h00, 1'b1);
        end
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Presents one request, idling between bursts, and predicts it once taken.
    task automatic issue(input logic [1:0] op, input logic [7:0] b,
                         input bit typed = 1'b0, input t_res want = '0);
        t_cmd c;
        bit pause;
        bit drain;
        c.opcode = op;
        c.rx_byte = b;
        pause = idle_on && burst_left == 0;
        drain = ($urandom_range(0, 19) == 0);
        if (pause || drain) begin
            start <= 1'b0;
            if (pause) burst_left = $urandom_range(1, 8);
            while (drain && bytes_due.size() != 0) @(posedge i_clk);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        ring_apply(op, b);
        if (typed) begin
            void'(bytes_due.pop_back());
            bytes_due.push_back(want);
        end
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Register writes wait until the block has gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ix, input logic [7:0] v);
        start <= 1'b0;
        while (bytes_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (ix == CFG_HEADER) hdr_val = v;
        else ack_floor = v[5:0];
    endtask

    // One random sequence: mostly well-formed packets with random content.
    task automatic random_episode();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            repeat ($urandom_range(0, 3)) issue(OP_RX, 8'($urandom));
            issue(OP_RX, hdr_val);
            repeat (PACKET_BYTES_DEF - 1) issue(OP_RX, 8'($urandom));
            issue(OP_DATA, 8'($urandom));
        end else if (pick < 7) begin
            // Thin out a crowded ring so the acknowledge window can open.
            if (held > 20) issue(OP_DATA, 8'($urandom));
            repeat ($urandom_range(0, 2)) issue(OP_RX, 8'($urandom));
            issue(OP_RX, ASCII_O);
            issue(OP_RX, ASCII_K);
            repeat ($urandom_range(0, 4)) issue(OP_RX, 8'($urandom));
            issue(OP_ACK, 8'($urandom));
        end else if (pick == 7) begin
            // Broken sequences: a short packet or a lone 'O'.
            if ($urandom_range(0, 1) == 0) begin
                issue(OP_RX, hdr_val);
                repeat ($urandom_range(0, 10)) issue(OP_RX, 8'($urandom));
                issue(OP_DATA, 8'($urandom));
            end else begin
                issue(OP_RX, ASCII_O);
                issue(OP_RX, 8'($urandom));
                issue(OP_ACK, 8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 3)) issue(2'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    // Each strobed result is checked against the oldest byte still owed.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            results_seen++;
            if (o_res.last) begin
                if (o_res.status == ST_DATA) data_pkts++;
                else if (o_res.status == ST_ACK) ack_pkts++;
                else empty_searches++;
            end
            if (bytes_due.size() == 0) begin
                flag_mismatch("result with nothing owed, byte", o_res.out_byte, 0);
            end else begin
                want = bytes_due.pop_front();
                if (o_res.status != want.status)
                    flag_mismatch("status", o_res.status, want.status);
                if (o_res.out_byte != want.out_byte)
                    flag_mismatch("out_byte", o_res.out_byte, want.out_byte);
                if (o_res.last != want.last)
                    flag_mismatch("last", o_res.last, want.last);
                if (o_res.packet_total != want.packet_total)
                    flag_mismatch("packet_total", o_res.packet_total, want.packet_total);
                if (o_res.ack_seen != want.ack_seen)
                    flag_mismatch("ack_seen", o_res.ack_seen, want.ack_seen);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d bytes owed", cycle_count,
                     bytes_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int ph_start;
        // Directed script: empty-ring searches, the ignored opcode, a packet
        // behind one stray byte, an acknowledge, an empty ring with no lower
        // bound on the window, and an acknowledge search halted by a header.
        script = '{
            fail_row(OP_DATA, 8'd0, 1'b0),
            fail_row(OP_ACK, 8'd0, 1'b0),
            req_row(OP_UNUSED),
            rx_row(8'h00), rx_row(8'hAA), rx_row(8'hFF), rx_row(8'h4F),
            rx_row(8'h4B), rx_row(8'h01), rx_row(8'h80), rx_row(8'h7F),
            rx_row(8'h55), rx_row(8'h02), rx_row(8'h04), rx_row(8'h08),
            rx_row(8'h10), rx_row(8'h20), rx_row(8'h40), rx_row(8'hFE),
            rx_row(8'h33),
            req_row(OP_DATA),
            rx_row(ASCII_O), rx_row(ASCII_K),
            req_row(OP_ACK),
            reg_row(CFG_ACK_MIN, 8'd0),
            fail_row(OP_ACK, 8'd1, 1'b1),
            reg_row(CFG_ACK_MIN, 8'd2),
            reg_row(CFG_HEADER, 8'hFF),
            rx_row(8'hFF), rx_row(8'hFF),
            fail_row(OP_ACK, 8'd1, 1'b1)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_reg) write_reg(script[i].reg_ix, script[i].val);
            else issue(script[i].op, script[i].val, script[i].typed, script[i].want);
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_HEADER, 8'($urandom_range(0, 255)));
                    write_reg(CFG_ACK_MIN, 8'($urandom_range(2, 8)));
                end
                1: begin
                    write_reg(CFG_HEADER, 8'h00);
                    write_reg(CFG_ACK_MIN, 8'd63);
                end
                2: begin
                    write_reg(CFG_HEADER, 8'hFF);
                    write_reg(CFG_ACK_MIN, 8'd2);
                end
                default: begin
                    write_reg(CFG_HEADER, HEADER_RESET);
                    write_reg(CFG_ACK_MIN, 8'($urandom_range(2, 31)));
                end
            endcase
            idle_on = (ph != 2);
            // Overrun the ring once so that a full ring gets emptied.
            if (ph == 1) begin
                while (held < RING_DEPTH_DEF) issue(OP_RX, 8'($urandom));
                issue(OP_RX, 8'($urandom));
                issue(OP_DATA, 8'($urandom));
            end
            ph_start = items_sent;
            while (items_sent - ph_start < PHASE_ITEMS) random_episode();
        end

        start <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests in the directed script and four random phases; %0s %0d",
                 items_sent, "checked result bytes:", results_seen);
        $display("Seen %0d data packets, %0d acknowledge packets, %0d failed searches.",
                 data_pkts, ack_pkts, empty_searches);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/uprr_pkg.sv
src/uprr_ring_mem.sv
src/uprr_ctrl.sv
src/uart_packet_ring_resync.sv
test/uart_packet_ring_resync_tb.sv
